// ===== hdl/knnbc_pkg.sv =====
// Shared constants, codes and control structs for the k-NN classifier.
`default_nettype none
package knnbc_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int MAX_K_DEF      = 8;
  localparam int COORD_BITS_DEF = 16;

  localparam int KIND_W = 2;
  localparam int K_W    = 4;
  localparam int VOTE_W = 4;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [K_W-1:0] K_RESET = 4'd1;

  localparam logic CLASS_A = 1'b0;
  localparam logic CLASS_B = 1'b1;

  // store commands from the sequencer
  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } store_cmd_t;

  // control into the neighbor list
  typedef struct packed {
    logic clear;
    logic ins_vld;
    logic ins_label;
  } rank_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/knnbc_ifs.sv =====
// Channel interfaces: query/training input, classification result, k register write.
`default_nettype none
interface knnbc_in_if #(
  parameter int COORD_BITS = knnbc_pkg::COORD_BITS_DEF
);
  import knnbc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic        [KIND_W-1:0]     kind;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         label;
  modport source (output valid, kind, coord_x, coord_y, coord_z, label, input ready);
  modport sink   (input valid, kind, coord_x, coord_y, coord_z, label, output ready);
endinterface

interface knnbc_out_if;
  import knnbc_pkg::*;
  logic              valid;
  logic              ready;
  logic              predicted_class;
  logic [VOTE_W-1:0] votes_a;
  logic [VOTE_W-1:0] votes_b;
  logic              store_empty;
  modport source (output valid, predicted_class, votes_a, votes_b, store_empty, input ready);
  modport sink   (input valid, predicted_class, votes_a, votes_b, store_empty, output ready);
endinterface

interface knnbc_cfg_if;
  import knnbc_pkg::*;
  logic           valid;
  logic           ready;
  logic [K_W-1:0] k_neighbors;
  modport source (output valid, k_neighbors, input ready);
  modport sink   (input valid, k_neighbors, output ready);
endinterface
`default_nettype wire

// ===== hdl/knnbc_store.sv =====
// Training point memory with fill count and one registered read port.
`default_nettype none
module knnbc_store #(
  parameter int MAX_POINTS = knnbc_pkg::MAX_POINTS_DEF,
  parameter int PT_W       = 49,
  parameter int IDX_W      = $clog2(MAX_POINTS),
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  knnbc_pkg::store_cmd_t   cmd,
  input  wire  [PT_W-1:0]         wr_data,
  input  wire  [IDX_W-1:0]        rd_addr,
  output logic [CNT_W-1:0]        count,
  output logic [PT_W-1:0]         rd_data,
  output logic                    rd_vld
);
  import knnbc_pkg::*;

  logic [PT_W-1:0]  mem [MAX_POINTS];
  logic [CNT_W-1:0] cnt_r;
  logic [PT_W-1:0]  rd_data_r;
  logic             rd_vld_r;

  // entries at or above the count are never read, so no clearing pass
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.clear) begin
        cnt_r <= '0;
      end else if (cmd.wr_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign count   = cnt_r;
  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule
`default_nettype wire

// ===== hdl/knnbc_dist.sv =====
// Squared distance pipeline: difference, square, sum, one register each.
`default_nettype none
module knnbc_dist #(
  parameter int COORD_BITS = knnbc_pkg::COORD_BITS_DEF,
  parameter int PT_W       = 3 * COORD_BITS + 1,
  parameter int DIST_W     = 2 * COORD_BITS + 2
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_vld,
  input  wire  [PT_W-1:0]             pt,
  input  wire  signed [COORD_BITS-1:0] qx,
  input  wire  signed [COORD_BITS-1:0] qy,
  input  wire  signed [COORD_BITS-1:0] qz,
  output logic                        out_vld,
  output logic [DIST_W-1:0]           sq_dist,
  output logic                        label,
  output logic                        busy
);
  import knnbc_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int SQ_W = 2 * COORD_BITS;

  logic signed [C:0] dx, dy, dz;
  logic [C:0]        ax, ay, az;
  logic [C-1:0]      mx_r, my_r, mz_r;
  logic [SQ_W-1:0]   px, py, pz;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [DIST_W-1:0] sum;
  logic [DIST_W-1:0] dist_r;
  logic              v1_r, v2_r, v3_r;
  logic              l1_r, l2_r, l3_r;

  always_comb begin
    dx = {pt[3*C-1], pt[3*C-1:2*C]} - {qx[C-1], qx};
    dy = {pt[2*C-1], pt[2*C-1:C]}   - {qy[C-1], qy};
    dz = {pt[C-1],   pt[C-1:0]}     - {qz[C-1], qz};
    ax = dx[C] ? -dx : dx;
    ay = dy[C] ? -dy : dy;
    az = dz[C] ? -dz : dz;
  end

  // magnitude fits C bits, so each product fits exactly
  assign px  = mx_r * mx_r;
  assign py  = my_r * my_r;
  assign pz  = mz_r * mz_r;
  assign sum = DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);

  always_ff @(posedge clk) begin
    mx_r   <= ax[C-1:0];
    my_r   <= ay[C-1:0];
    mz_r   <= az[C-1:0];
    l1_r   <= pt[PT_W-1];
    sx_r   <= px;
    sy_r   <= py;
    sz_r   <= pz;
    l2_r   <= l1_r;
    dist_r <= sum;
    l3_r   <= l2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_vld = v3_r;
  assign sq_dist = dist_r;
  assign label   = l3_r;
  assign busy    = v1_r | v2_r | v3_r;

endmodule
`default_nettype wire

// ===== hdl/knnbc_rank.sv =====
// Sorted list of the nearest neighbors seen so far, with the vote count.
`default_nettype none
module knnbc_rank #(
  parameter int MAX_K  = knnbc_pkg::MAX_K_DEF,
  parameter int DIST_W = 34,
  parameter int KC_W   = $clog2(MAX_K + 1)
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  knnbc_pkg::rank_ctl_t   ctl,
  input  wire  [DIST_W-1:0]      ins_dist,
  input  wire  [KC_W-1:0]        kcap,
  output logic [KC_W-1:0]        votes_a,
  output logic [KC_W-1:0]        votes_b
);
  import knnbc_pkg::*;

  logic [DIST_W-1:0] dist_r [MAX_K];
  logic [MAX_K-1:0]  lab_r;
  logic [MAX_K-1:0]  vld_r;
  logic [MAX_K-1:0]  ge;

  // equal distance does not displace: earlier (lower index) point stays ahead
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      ge[i] = !vld_r[i] || (ins_dist < dist_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_K; i++) begin
      if (ctl.ins_vld && ge[i]) begin
        if (i == 0 || !ge[(i == 0) ? 0 : i-1]) begin
          dist_r[i] <= ins_dist;
          lab_r[i]  <= ctl.ins_label;
        end else begin
          dist_r[i] <= dist_r[(i == 0) ? 0 : i-1];
          lab_r[i]  <= lab_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clear) begin
      vld_r <= '0;
    end else if (ctl.ins_vld) begin
      for (int i = 0; i < MAX_K; i++) begin
        if (ge[i]) begin
          vld_r[i] <= (i == 0 || !ge[(i == 0) ? 0 : i-1]) ? 1'b1 : vld_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  always_comb begin
    votes_a = '0;
    votes_b = '0;
    for (int i = 0; i < MAX_K; i++) begin
      if (vld_r[i] && (KC_W'(i) < kcap)) begin
        if (lab_r[i] == CLASS_B) begin
          votes_b = votes_b + 1'b1;
        end else begin
          votes_a = votes_a + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/knn_binary_classifier_3d.sv =====
// Channel     | Dir | Payload
// in_ch       | in  | kind, coord_x, coord_y, coord_z, label
// out_ch      | out | predicted_class, votes_a, votes_b, store_empty
// cfg_ch      | in  | k_neighbors
//
// A query reads the point memory one entry per cycle, then the distance
// pipeline drains; a query on an empty store skips both. rst_n is
// synchronous; the point memory is not cleared, only the fill count. The
// result sits in an output register, so new items are taken while it waits;
// a finished query holds only if the previous result has not been
// transferred yet.
`default_nettype none
module knn_binary_classifier_3d #(
  parameter int MAX_POINTS = knnbc_pkg::MAX_POINTS_DEF,
  parameter int MAX_K      = knnbc_pkg::MAX_K_DEF,
  parameter int COORD_BITS = knnbc_pkg::COORD_BITS_DEF
) (
  input wire            clk,
  input wire            rst_n,
  knnbc_in_if.sink      in_ch,
  knnbc_out_if.source   out_ch,
  knnbc_cfg_if.sink     cfg_ch
);
  import knnbc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int KC_W   = $clog2(MAX_K + 1);
  localparam int PT_W   = 3 * COORD_BITS + 1;
  localparam int DIST_W = 2 * COORD_BITS + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [KC_W-1:0]              kcap_r, kcap_nxt;
  logic                         empty_r, empty_nxt;
  logic [K_W-1:0]               k_cfg_r;
  logic signed [COORD_BITS-1:0] qx_r, qy_r, qz_r;
  logic                         out_vld_r, out_vld_nxt;
  logic                         cls_r, cls_nxt;
  logic [VOTE_W-1:0]            va_r, va_nxt, vb_r, vb_nxt;
  logic                         emp_o_r, emp_o_nxt;

  logic                 in_acc;
  logic                 q_start;
  store_cmd_t           scmd;
  rank_ctl_t            rctl;
  logic [CNT_W-1:0]     cnt;
  logic [PT_W-1:0]      rd_data;
  logic                 rd_vld;
  logic                 d_vld;
  logic [DIST_W-1:0]    d_dist;
  logic                 d_label;
  logic                 d_busy;
  logic [KC_W-1:0]      votes_a, votes_b;
  logic [KC_W-1:0]      kcap_calc;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign q_start      = in_acc && (in_ch.kind == KIND_QUERY);
  assign cfg_ch.ready = 1'b1;

  assign scmd.clear = in_acc && (in_ch.kind == KIND_CLEAR);
  assign scmd.wr_en = in_acc && (in_ch.kind == KIND_APPEND) && (cnt < CNT_W'(MAX_POINTS));
  assign scmd.rd_en = (state_r == ST_SCAN);

  assign rctl.clear     = q_start;
  assign rctl.ins_vld   = d_vld;
  assign rctl.ins_label = d_label;

  // k limited by the list depth and by the number of stored points
  always_comb begin
    int kk;
    kk = int'(k_cfg_r);
    if (kk > MAX_K) begin
      kk = MAX_K;
    end
    if (kk > int'(cnt)) begin
      kk = int'(cnt);
    end
    kcap_calc = KC_W'(kk);
  end

  knnbc_store #(
    .MAX_POINTS (MAX_POINTS),
    .PT_W       (PT_W),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (scmd),
    .wr_data ({in_ch.label, in_ch.coord_x, in_ch.coord_y, in_ch.coord_z}),
    .rd_addr (idx_r),
    .count   (cnt),
    .rd_data (rd_data),
    .rd_vld  (rd_vld)
  );

  knnbc_dist #(
    .COORD_BITS (COORD_BITS),
    .PT_W       (PT_W),
    .DIST_W     (DIST_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld),
    .pt      (rd_data),
    .qx      (qx_r),
    .qy      (qy_r),
    .qz      (qz_r),
    .out_vld (d_vld),
    .sq_dist (d_dist),
    .label   (d_label),
    .busy    (d_busy)
  );

  knnbc_rank #(
    .MAX_K  (MAX_K),
    .DIST_W (DIST_W),
    .KC_W   (KC_W)
  ) u_rank (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rctl),
    .ins_dist (d_dist),
    .kcap     (kcap_r),
    .votes_a  (votes_a),
    .votes_b  (votes_b)
  );

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    kcap_nxt    = kcap_r;
    empty_nxt   = empty_r;
    out_vld_nxt = out_vld_r;
    cls_nxt     = cls_r;
    va_nxt      = va_r;
    vb_nxt      = vb_r;
    emp_o_nxt   = emp_o_r;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_start) begin
          idx_nxt   = '0;
          kcap_nxt  = kcap_calc;
          empty_nxt = (cnt == '0);
          state_nxt = (cnt == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (CNT_W'(idx_r) == cnt - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !d_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          emp_o_nxt   = empty_r;
          if (empty_r) begin
            cls_nxt = CLASS_B;
            va_nxt  = '0;
            vb_nxt  = '0;
          end else begin
            cls_nxt = (votes_a > votes_b) ? CLASS_A : CLASS_B;
            va_nxt  = VOTE_W'(votes_a);
            vb_nxt  = VOTE_W'(votes_b);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      k_cfg_r   <= K_RESET;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        k_cfg_r <= cfg_ch.k_neighbors;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    kcap_r  <= kcap_nxt;
    empty_r <= empty_nxt;
    cls_r   <= cls_nxt;
    va_r    <= va_nxt;
    vb_r    <= vb_nxt;
    emp_o_r <= emp_o_nxt;
    if (q_start) begin
      qx_r <= in_ch.coord_x;
      qy_r <= in_ch.coord_y;
      qz_r <= in_ch.coord_z;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.predicted_class = cls_r;
  assign out_ch.votes_a         = va_r;
  assign out_ch.votes_b         = vb_r;
  assign out_ch.store_empty     = emp_o_r;

endmodule
`default_nettype wire
